// ===== design/fzs_pkg.sv =====
// Shared constants, types and membership functions of the fuzzy scorer.
package fzs_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int Q_BITS        = 12;
	localparam int IN_W          = 16;
	localparam int BP_W          = IN_W + 1;
	localparam int MEM_W         = Q_BITS + 1;
	localparam int LEVEL_W       = 8;
	localparam int SCORE_W       = 16;
	localparam int SUM_W         = MEM_W + 2;
	localparam int NUM_W         = SUM_W + LEVEL_W;
	localparam int QUO_W         = LEVEL_W + FRACTION_BITS;
	localparam int DIV_BPS       = 2;
	localparam int DIV_ST        = (QUO_W + DIV_BPS - 1) / DIV_BPS;
	localparam int CFG_IDX_W     = 2;
	localparam int SCORE_MAX     = (1 << SCORE_W) - 1;

	localparam logic [MEM_W-1:0] ONE_Q12 = MEM_W'(1 << Q_BITS);

	// floor(v / 3) as (v * RECIP3) >> RECIP3_SH, exact for v up to 3 << Q_BITS
	localparam int SLOPE_W   = Q_BITS + 2;
	localparam int RECIP3_W  = 17;
	localparam int RECIP3_SH = 17;
	localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(43691);

	localparam logic [BP_W-1:0] INC_8  = BP_W'(8 << FRACTION_BITS);
	localparam logic [BP_W-1:0] INC_11 = BP_W'(11 << FRACTION_BITS);
	localparam logic [BP_W-1:0] INC_13 = BP_W'(13 << FRACTION_BITS);
	localparam logic [BP_W-1:0] INC_16 = BP_W'(16 << FRACTION_BITS);
	localparam logic [BP_W-1:0] EXP_5  = BP_W'(5 << FRACTION_BITS);
	localparam logic [BP_W-1:0] EXP_7  = BP_W'(7 << FRACTION_BITS);
	localparam logic [BP_W-1:0] EXP_8  = BP_W'(8 << FRACTION_BITS);
	localparam logic [BP_W-1:0] EXP_10 = BP_W'(10 << FRACTION_BITS);

	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CONSIDER = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_REJECT   = CFG_IDX_W'(2);

	localparam logic [LEVEL_W-1:0] ACCEPT_RST   = LEVEL_W'(100);
	localparam logic [LEVEL_W-1:0] CONSIDER_RST = LEVEL_W'(70);
	localparam logic [LEVEL_W-1:0] REJECT_RST   = LEVEL_W'(50);

	typedef struct packed {
		logic [MEM_W-1:0] low;
		logic [MEM_W-1:0] mid;
		logic [MEM_W-1:0] high;
		logic [MEM_W-1:0] frugal;
		logic [MEM_W-1:0] moder;
		logic [MEM_W-1:0] waste;
	} memb_t;

	typedef struct packed {
		logic [MEM_W-1:0] acc;
		logic [MEM_W-1:0] con;
		logic [MEM_W-1:0] rej;
	} str_t;

	// sloped part: d * 4096 / span, span three or two units
	function automatic logic [MEM_W-1:0] slope(input logic [BP_W-1:0] d, input logic span3);
		logic [BP_W+Q_BITS-1:0]      t;
		logic [SLOPE_W-1:0]          v3;
		logic [SLOPE_W+RECIP3_W-1:0] p;
		t  = {d, {Q_BITS{1'b0}}};
		v3 = SLOPE_W'(t >> FRACTION_BITS);
		p  = v3 * RECIP3;
		if (span3) begin
			slope = p[RECIP3_SH +: MEM_W];
		end else begin
			slope = MEM_W'(t >> (FRACTION_BITS + 1));
		end
	endfunction

	function automatic logic [MEM_W-1:0] rise(input logic [BP_W-1:0] x,
		input logic [BP_W-1:0] a, input logic [BP_W-1:0] b, input logic span3);
		if (x < a) begin
			rise = '0;
		end else if (x >= b) begin
			rise = ONE_Q12;
		end else begin
			rise = slope(x - a, span3);
		end
	endfunction

	function automatic logic [MEM_W-1:0] fall(input logic [BP_W-1:0] x,
		input logic [BP_W-1:0] a, input logic [BP_W-1:0] b, input logic span3);
		if (x < a) begin
			fall = ONE_Q12;
		end else if (x >= b) begin
			fall = '0;
		end else begin
			fall = slope(b - x, span3);
		end
	endfunction

	function automatic logic [MEM_W-1:0] trap(input logic [BP_W-1:0] x,
		input logic [BP_W-1:0] a, input logic [BP_W-1:0] b,
		input logic [BP_W-1:0] c, input logic [BP_W-1:0] d, input logic span3);
		if (x < a || x >= d) begin
			trap = '0;
		end else if (x < b) begin
			trap = rise(x, a, b, span3);
		end else if (x < c) begin
			trap = ONE_Q12;
		end else begin
			trap = fall(x, c, d, span3);
		end
	endfunction

	function automatic logic [MEM_W-1:0] fmin(input logic [MEM_W-1:0] a,
		input logic [MEM_W-1:0] b);
		fmin = (a < b) ? a : b;
	endfunction

	function automatic logic [MEM_W-1:0] fmax(input logic [MEM_W-1:0] a,
		input logic [MEM_W-1:0] b);
		fmax = (a > b) ? a : b;
	endfunction

endpackage

// ===== design/fzs_memb.sv =====
// Fuzzification stage: six membership degrees from income and expense.
module fzs_memb (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [fzs_pkg::IN_W-1:0]  income,
	input  logic [fzs_pkg::IN_W-1:0]  expense,
	output logic                      out_valid,
	input  logic                      out_stall,
	output fzs_pkg::memb_t            memb
);
	import fzs_pkg::*;

	logic            vld_s1;
	logic            adv;
	memb_t           memb_s1;
	memb_t           memb_nx;
	logic [BP_W-1:0] xi;
	logic [BP_W-1:0] xe;

	assign adv      = ~vld_s1 | ~out_stall;
	assign in_stall = ~adv;
	assign xi       = {1'b0, income};
	assign xe       = {1'b0, expense};

	always_comb begin
		memb_nx.low    = fall(xi, INC_8, INC_11, 1'b1);
		memb_nx.mid    = trap(xi, INC_8, INC_11, INC_13, INC_16, 1'b1);
		memb_nx.high   = rise(xi, INC_13, INC_16, 1'b1);
		memb_nx.frugal = fall(xe, EXP_5, EXP_7, 1'b0);
		memb_nx.moder  = trap(xe, EXP_5, EXP_7, EXP_8, EXP_10, 1'b0);
		memb_nx.waste  = rise(xe, EXP_8, EXP_10, 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			memb_s1 <= memb_nx;
		end
	end

	assign out_valid = vld_s1;
	assign memb      = memb_s1;

endmodule

// ===== design/fzs_infer.sv =====
// Rule evaluation and weighted numerator and strength sum, two stages.
module fzs_infer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  fzs_pkg::memb_t               memb,
	input  logic [fzs_pkg::LEVEL_W-1:0]  accept_level,
	input  logic [fzs_pkg::LEVEL_W-1:0]  consider_level,
	input  logic [fzs_pkg::LEVEL_W-1:0]  reject_level,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fzs_pkg::NUM_W-1:0]    num,
	output logic [fzs_pkg::SUM_W-1:0]    den,
	output fzs_pkg::str_t                strength
);
	import fzs_pkg::*;

	logic             vld_s2;
	logic             vld_s3;
	logic             adv2;
	logic             adv3;
	str_t             str_nx;
	str_t             str_s2;
	str_t             str_s3;
	logic [NUM_W-1:0] num_nx;
	logic [SUM_W-1:0] den_nx;
	logic [NUM_W-1:0] num_s3;
	logic [SUM_W-1:0] den_s3;

	assign adv3     = ~vld_s3 | ~out_stall;
	assign adv2     = ~vld_s2 | adv3;
	assign in_stall = ~adv2;

	always_comb begin
		str_nx.acc = fmax(fmax(fmin(memb.mid, memb.waste), fmin(memb.low, memb.waste)),
			fmin(memb.low, memb.moder));
		str_nx.con = fmax(fmax(fmin(memb.high, memb.waste), fmin(memb.mid, memb.moder)),
			fmin(memb.low, memb.frugal));
		str_nx.rej = fmax(fmax(fmin(memb.high, memb.moder), fmin(memb.high, memb.frugal)),
			fmin(memb.mid, memb.frugal));
	end

	always_comb begin
		num_nx = NUM_W'(str_s2.acc * accept_level) + NUM_W'(str_s2.con * consider_level)
			+ NUM_W'(str_s2.rej * reject_level);
		den_nx = SUM_W'(str_s2.acc) + SUM_W'(str_s2.con) + SUM_W'(str_s2.rej);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				vld_s2 <= in_valid;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			str_s2 <= str_nx;
		end
		if (adv3 && vld_s2) begin
			str_s3 <= str_s2;
			num_s3 <= num_nx;
			den_s3 <= den_nx;
		end
	end

	assign out_valid = vld_s3;
	assign num       = num_s3;
	assign den       = den_s3;
	assign strength  = str_s3;

endmodule

// ===== design/fzs_div.sv =====
// Pipelined restoring divider for the score, two quotient bits per stage.
module fzs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [fzs_pkg::NUM_W-1:0]    num,
	input  logic [fzs_pkg::SUM_W-1:0]    den,
	input  fzs_pkg::str_t                strength,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fzs_pkg::SCORE_W-1:0]  score,
	output fzs_pkg::str_t                out_strength
);
	import fzs_pkg::*;

	localparam logic [QUO_W-1:0] QUO_CAP = QUO_W'(SCORE_MAX);

	logic             vld_s  [DIV_ST];
	logic             adv    [DIV_ST];
	logic [SUM_W-1:0] rem_s  [DIV_ST];
	logic [SUM_W-1:0] den_s  [DIV_ST];
	logic [QUO_W-1:0] dvd_s  [DIV_ST];
	logic [QUO_W-1:0] quo_s  [DIV_ST];
	logic             zero_s [DIV_ST];
	str_t             str_s  [DIV_ST];

	for (genvar k = 0; k < DIV_ST; k++) begin : g_st
		logic             vld_i;
		logic [SUM_W-1:0] rem_i;
		logic [SUM_W-1:0] den_i;
		logic [QUO_W-1:0] dvd_i;
		logic [QUO_W-1:0] quo_i;
		logic             zero_i;
		str_t             str_i;
		logic             adv_nx;
		logic [SUM_W-1:0] rem_n;
		logic [QUO_W-1:0] dvd_n;
		logic [QUO_W-1:0] quo_n;
		logic [SUM_W:0]   t;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rem_i  = num[NUM_W-1 -: SUM_W];
			assign den_i  = den;
			assign dvd_i  = {num[LEVEL_W-1:0], {FRACTION_BITS{1'b0}}};
			assign quo_i  = '0;
			assign zero_i = (den == '0);
			assign str_i  = strength;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign den_i  = den_s[k-1];
			assign dvd_i  = dvd_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign zero_i = zero_s[k-1];
			assign str_i  = str_s[k-1];
		end

		if (k == DIV_ST - 1) begin : g_last
			assign adv_nx = ~out_stall;
		end else begin : g_mid
			assign adv_nx = adv[k+1];
		end

		assign adv[k] = ~vld_s[k] | adv_nx;

		always_comb begin
			rem_n = rem_i;
			dvd_n = dvd_i;
			quo_n = quo_i;
			t     = '0;
			for (int j = 0; j < DIV_BPS; j++) begin
				if (k * DIV_BPS + j < QUO_W) begin
					t     = {rem_n, dvd_n[QUO_W-1]};
					dvd_n = {dvd_n[QUO_W-2:0], 1'b0};
					if (t >= {1'b0, den_i}) begin
						rem_n = SUM_W'(t - {1'b0, den_i});
						quo_n = {quo_n[QUO_W-2:0], 1'b1};
					end else begin
						rem_n = t[SUM_W-1:0];
						quo_n = {quo_n[QUO_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && vld_i) begin
				rem_s[k]  <= rem_n;
				den_s[k]  <= den_i;
				dvd_s[k]  <= dvd_n;
				quo_s[k]  <= quo_n;
				zero_s[k] <= zero_i;
				str_s[k]  <= str_i;
			end
		end
	end

	assign in_stall     = ~adv[0];
	assign out_valid    = vld_s[DIV_ST-1];
	assign out_strength = str_s[DIV_ST-1];

	always_comb begin
		if (zero_s[DIV_ST-1]) begin
			score = '0;
		end else if (quo_s[DIV_ST-1] > QUO_CAP) begin
			score = SCORE_W'(SCORE_MAX);
		end else begin
			score = SCORE_W'(quo_s[DIV_ST-1]);
		end
	end

endmodule

// ===== design/fuzzy_sugeno_two_input_scorer_top.sv =====
// Top level of the two-input zero-order Sugeno fuzzy scorer.
//
// Each item carries income and expense (unsigned Q8.8, millions) and yields one
// result: the accept, consider and reject firing strengths (Q1.12) and the score,
// the strength-weighted mean of the three level registers in Q8.8, truncated.
// The block takes one item per cycle unless stalled, with no dependence between
// items. Each item passes fuzzification, rule evaluation, weighted sum, then eight
// stages of a restoring divider that settles two quotient bits each. Stalls back
// up stage by stage, so empty stages keep filling while a result waits. The level
// registers are read live; write them only while the pipeline is empty.
module fuzzy_sugeno_two_input_scorer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fzs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fzs_pkg::LEVEL_W-1:0]    cfg_wdata,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [fzs_pkg::IN_W-1:0]       income,
	input  logic [fzs_pkg::IN_W-1:0]       expense,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [fzs_pkg::SCORE_W-1:0]    score,
	output logic [fzs_pkg::MEM_W-1:0]      accept_strength,
	output logic [fzs_pkg::MEM_W-1:0]      consider_strength,
	output logic [fzs_pkg::MEM_W-1:0]      reject_strength
);
	import fzs_pkg::*;

	logic [LEVEL_W-1:0] accept_level_q;
	logic [LEVEL_W-1:0] consider_level_q;
	logic [LEVEL_W-1:0] reject_level_q;

	logic               memb_valid;
	logic               memb_stall;
	memb_t              memb;
	logic               inf_valid;
	logic               inf_stall;
	logic [NUM_W-1:0]   num;
	logic [SUM_W-1:0]   den;
	str_t               strength;
	str_t               res_strength;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_level_q   <= ACCEPT_RST;
			consider_level_q <= CONSIDER_RST;
			reject_level_q   <= REJECT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ACCEPT:   accept_level_q   <= cfg_wdata;
				REG_CONSIDER: consider_level_q <= cfg_wdata;
				REG_REJECT:   reject_level_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fzs_memb u_memb (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_stall  (item_stall),
		.income    (income),
		.expense   (expense),
		.out_valid (memb_valid),
		.out_stall (memb_stall),
		.memb      (memb)
	);

	fzs_infer u_infer (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (memb_valid),
		.in_stall       (memb_stall),
		.memb           (memb),
		.accept_level   (accept_level_q),
		.consider_level (consider_level_q),
		.reject_level   (reject_level_q),
		.out_valid      (inf_valid),
		.out_stall      (inf_stall),
		.num            (num),
		.den            (den),
		.strength       (strength)
	);

	fzs_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (inf_valid),
		.in_stall     (inf_stall),
		.num          (num),
		.den          (den),
		.strength     (strength),
		.out_valid    (result_valid),
		.out_stall    (result_stall),
		.score        (score),
		.out_strength (res_strength)
	);

	assign accept_strength   = res_strength.acc;
	assign consider_strength = res_strength.con;
	assign reject_strength   = res_strength.rej;

endmodule
